// File: rtl/dfrem_pkg.sv
// ----------------------------------------------------------------------------
// dfrem_pkg
// shared types and constants for the double remainder block
// ----------------------------------------------------------------------------
package dfrem_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned FracW  = 52;
  localparam int unsigned ExpW   = 11;
  localparam int unsigned SigW   = 53;
  localparam int unsigned QDepth = 2;

  localparam logic [ExpW-1:0]  ExpAllOnes = 11'h7ff;
  localparam logic [WordW-1:0] NanReset   = 64'h7ff8_0000_0000_0000;
  localparam logic [SigW-1:0]  HiddenBit  = 53'h10_0000_0000_0000;

  // job handed from the classifier to the divider
  typedef struct packed {
    logic             bypass;
    logic             dom_err;
    logic [WordW-1:0] value;
    logic             sign;
    logic [SigW-1:0]  mx;
    logic [ExpW-1:0]  ex;
    logic [SigW-1:0]  my;
    logic [ExpW-1:0]  ey;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_NORM,
    ST_DONE
  } div_state_t;

endpackage

// File: rtl/dfrem_if.sv
// ----------------------------------------------------------------------------
// dfrem_if
// valid/ready channel interfaces
// ----------------------------------------------------------------------------
interface dfrem_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] dividend_bits;
  logic [63:0] divisor_bits;
  modport source (output valid, dividend_bits, divisor_bits, input ready);
  modport sink (input valid, dividend_bits, divisor_bits, output ready);
endinterface

interface dfrem_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] remainder_bits;
  logic        domain_error;
  modport source (output valid, remainder_bits, domain_error, input ready);
  modport sink (input valid, remainder_bits, domain_error, output ready);
endinterface

interface dfrem_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] nan_pattern;
  modport source (output valid, nan_pattern, input ready);
  modport sink (input valid, nan_pattern, output ready);
endinterface

// File: rtl/dfrem_front.sv
// ----------------------------------------------------------------------------
// dfrem_front
// classifies operands and queues jobs for the divider
// ----------------------------------------------------------------------------
module dfrem_front
  import dfrem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dfrem_in_if.sink    in_ch,
  input  logic [WordW-1:0] nan_pat,
  output logic        job_valid,
  input  logic        job_take,
  output job_t        job
);

  job_t q_r [QDepth];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;

  logic [WordW-1:0] x, y, ax, ay;
  logic [ExpW-1:0] bx, by;
  logic x_inf, y_nan, y_zero, bad;
  job_t nj;

  assign x  = in_ch.dividend_bits;
  assign y  = in_ch.divisor_bits;
  assign ax = {1'b0, x[WordW-2:0]};
  assign ay = {1'b0, y[WordW-2:0]};
  assign bx = x[WordW-2:FracW];
  assign by = y[WordW-2:FracW];

  always_comb begin
    x_inf  = (bx == ExpAllOnes);
    y_nan  = (by == ExpAllOnes) && (y[FracW-1:0] != '0);
    y_zero = (ay == '0);
    bad    = x_inf || y_nan || y_zero;
    nj.dom_err = bad;
    nj.bypass  = bad || (ax < ay);
    nj.value   = bad ? nan_pat : x;
    nj.sign    = x[WordW-1];
    nj.mx = {(bx != '0), x[FracW-1:0]};
    nj.ex = (bx == '0) ? ExpW'(1) : bx;
    nj.my = {(by != '0), y[FracW-1:0]};
    nj.ey = (by == '0) ? ExpW'(1) : by;
  end

  assign in_ch.ready = (cnt_r != 2'(QDepth));
  assign job_valid   = (cnt_r != '0);
  assign job         = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      q_r[wr_r] <= nj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) wr_r <= ~wr_r;
      if (job_take) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(in_ch.valid && in_ch.ready) - 2'(job_take);
    end
  end

`ifndef SYNTHESIS
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid) else $error("take from empty queue");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDepth)) else $error("queue overflow");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QDepth)) |-> !in_ch.ready) else $error("ready when full");
`endif

endmodule

// File: rtl/dfrem_back.sv
// ----------------------------------------------------------------------------
// dfrem_back
// shift-subtract divider, normaliser and result register
// ----------------------------------------------------------------------------
module dfrem_back
  import dfrem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_take,
  input  job_t        job,
  dfrem_out_if.source out_ch
);

  div_state_t st_r, st_nxt;
  logic [WordW-1:0] mx_r;
  logic [SigW-1:0]  my_r;
  logic [ExpW-1:0]  ex_r, ey_r;
  logic             sign_r;
  logic [WordW-1:0] res_r;
  logic             err_r;

  logic [WordW-1:0] my_ext;
  logic [WordW-1:0] sub;
  logic             ge;
  logic             hid;
  logic             out_free;

  assign my_ext = {{(WordW-SigW){1'b0}}, my_r};
  assign ge  = (mx_r >= my_ext);
  assign sub = ge ? (mx_r - my_ext) : mx_r;
  assign hid = (mx_r[WordW-1:FracW] != '0);
  assign out_free = !out_ch.valid || out_ch.ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (job_valid) st_nxt = job.bypass ? ST_DONE : ST_DIV;
      ST_DIV:  if (ex_r == ey_r) st_nxt = ST_NORM;
      ST_NORM: if (mx_r == '0 || hid || ex_r == ExpW'(1)) st_nxt = ST_DONE;
      ST_DONE: if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_take = (st_r == ST_IDLE) && job_valid;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        mx_r   <= {{(WordW-SigW){1'b0}}, job.mx};
        my_r   <= job.my;
        ex_r   <= job.ex;
        ey_r   <= job.ey;
        sign_r <= job.sign;
        res_r  <= job.value;
        err_r  <= job.dom_err;
      end
      ST_DIV: begin
        if (ex_r == ey_r) begin
          mx_r <= sub;
        end else begin
          mx_r <= {sub[WordW-2:0], 1'b0};
          ex_r <= ex_r - ExpW'(1);
        end
      end
      ST_NORM: begin
        if (mx_r == '0) begin
          res_r <= {sign_r, 63'd0};
        end else if (hid) begin
          res_r <= {sign_r, ex_r, mx_r[FracW-1:0]};
        end else if (ex_r == ExpW'(1)) begin
          res_r <= {sign_r, 11'd0, mx_r[FracW-1:0]};
        end else begin
          mx_r <= {mx_r[WordW-2:0], 1'b0};
          ex_r <= ex_r - ExpW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_DONE && out_free) begin
      out_ch.remainder_bits <= res_r;
      out_ch.domain_error   <= err_r;
    end
  end

`ifndef SYNTHESIS
  a_div_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (ex_r >= ey_r)) else $error("exponent underran divisor");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("stalled item dropped");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> (st_r != ST_IDLE)) else $error("take lost");
`endif

endmodule

// File: rtl/double_float_remainder.sv
// ----------------------------------------------------------------------------
// double_float_remainder
// exact binary64 fmod with configurable nan result
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | dividend_bits, divisor_bits
// out_    | out | remainder_bits, domain_error
// cfg_    | in  | nan_pattern
// a bypassed item goes from idle straight to done; any other item runs the
// one-bit-a-cycle shift-subtract loop and then the normaliser
// a two-entry job queue lets input be taken while the divider works
// reset clears queue, state and output valid; nan pattern resets to quiet nan
// a stalled output holds its item and the divider waits
module double_float_remainder
  import dfrem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dfrem_in_if.sink    in_ch,
  dfrem_out_if.source out_ch,
  dfrem_cfg_if.sink   cfg_ch
);

  logic [WordW-1:0] nan_r;
  logic job_valid, job_take;
  job_t job;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) nan_r <= NanReset;
    else if (cfg_ch.valid) nan_r <= cfg_ch.nan_pattern;
  end

  dfrem_front u_front (
    .clk, .rst_n, .in_ch, .nan_pat(nan_r), .job_valid, .job_take, .job
  );

  dfrem_back u_back (
    .clk, .rst_n, .job_valid, .job_take, .job, .out_ch
  );

endmodule

// File: verif/double_float_remainder_test.sv
// ----------------------------------------------------------------------------
// double_float_remainder_test
// self-checking bench for the binary64 remainder block: directed and random
// operand pairs across several nan patterns, bursty input, stalling output
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module double_float_remainder_test;
  import dfrem_pkg::*;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
  } operands_t;

  typedef struct packed {
    logic [63:0] rem;
    logic        dom;
  } fmod_result_t;

  localparam int unsigned IdleLimit = 20000;

  logic clk;
  logic rst_n;

  dfrem_in_if  in_ch ();
  dfrem_out_if out_ch ();
  dfrem_cfg_if cfg_ch ();

  double_float_remainder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  operands_t    pending_ops[$];
  fmod_result_t expected_rems[$];
  logic [63:0]  nan_reg;
  int           n_errors;
  int           idle_cycles;
  int           hold_off;
  bit           hold_req;
  bit           in_burst;
  int           burst_left;
  int           stall_phase;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predicted fmod of two binary64 patterns under the current nan pattern
  function automatic fmod_result_t predict_fmod(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] nan_val);
    fmod_result_t r;
    logic [63:0]  mx, my;
    int           ex, ey;
    logic [10:0]  bex, bey;
    bex = x[62:52];
    bey = y[62:52];
    r.dom = 1'b0;
    if (bex == ExpAllOnes || (bey == ExpAllOnes && y[51:0] != 0) || y[62:0] == 0) begin
      r.rem = nan_val;
      r.dom = 1'b1;
      return r;
    end
    if (x[62:0] < y[62:0]) begin
      r.rem = x;
      return r;
    end
    mx = (bex == 0) ? {12'd0, x[51:0]} : {12'd1, x[51:0]};
    my = (bey == 0) ? {12'd0, y[51:0]} : {12'd1, y[51:0]};
    ex = (bex == 0) ? 1 : bex;
    ey = (bey == 0) ? 1 : bey;
    while (ex > ey) begin
      if (mx >= my) mx = mx - my;
      mx = mx << 1;
      ex--;
    end
    if (mx >= my) mx = mx - my;
    if (mx == 0) begin
      r.rem = {x[63], 63'd0};
      return r;
    end
    while (mx < 64'h0010_0000_0000_0000 && ex > 1) begin
      mx = mx << 1;
      ex--;
    end
    if (mx < 64'h0010_0000_0000_0000) r.rem = {x[63], mx[62:0]};
    else r.rem = {x[63], 11'(ex), mx[51:0]};
    return r;
  endfunction

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    int          k;
    v = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    case (k)
      0: v[62:52] = 11'd0;
      1: v[62:52] = ExpAllOnes;
      2: v[62:52] = 11'($urandom_range(1000, 1050));
      3: v[51:0] = 52'd0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_pair(logic [63:0] x, logic [63:0] y);
    pending_ops.push_back('{x: x, y: y});
  endtask

  task automatic write_nan(logic [63:0] v);
    @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.nan_pattern <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    nan_reg = v;
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || expected_rems.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_burst    <= 1'b0;
      burst_left  <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rems.push_back(predict_fmod(in_ch.dividend_bits, in_ch.divisor_bits,
                                             nan_reg));
        void'(pending_ops.pop_front());
      end
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        in_burst   <= ~in_burst;
        burst_left <= in_burst ? $urandom_range(0, 6) : $urandom_range(1, 12);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (in_burst && pending_ops.size() > 0) begin
        in_ch.valid         <= 1'b1;
        in_ch.dividend_bits <= pending_ops[0].x;
        in_ch.divisor_bits  <= pending_ops[0].y;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    fmod_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase  <= 0;
      hold_off     <= 0;
      idle_cycles  <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rems.size() == 0) begin
          $error("remainder_bits: no item expected, actual %h", out_ch.remainder_bits);
          n_errors++;
        end else begin
          exp_r = expected_rems.pop_front();
          if (out_ch.remainder_bits !== exp_r.rem) begin
            $error("remainder_bits: expected %h actual %h", exp_r.rem,
                   out_ch.remainder_bits);
            n_errors++;
          end
          if (out_ch.domain_error !== exp_r.dom) begin
            $error("domain_error: expected %b actual %b", exp_r.dom, out_ch.domain_error);
            n_errors++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      stall_phase <= (stall_phase + 1) % 23;
      if (hold_req && hold_off == 0) hold_off <= 4000;
      else if (hold_off > 0) hold_off <= hold_off - 1;
      if (hold_off > 1 || (hold_req && hold_off == 0)) out_ch.ready <= 1'b0;
      else if (stall_phase < 8) out_ch.ready <= 1'b1;
      else if (stall_phase < 14) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= (stall_phase % 3 == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles > IdleLimit) begin
      $display("double_float_remainder_test: errors");
      $finish;
    end
  end

  initial begin
    logic [63:0] nan_values[4];
    n_errors       = 0;
    hold_req       = 1'b0;
    nan_reg        = NanReset;
    rst_n          = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.nan_pattern = '0;
    in_ch.valid    = 1'b0;
    in_ch.dividend_bits = '0;
    in_ch.divisor_bits  = '0;
    out_ch.ready   = 1'b0;
    nan_values = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h7ff8_0000_0000_0001,
                   64'hfff4_5a5a_a5a5_0f0f};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset nan pattern first
    add_pair(64'h4014_0000_0000_0000, 64'h4000_0000_0000_0000);
    add_pair(64'hc014_0000_0000_0000, 64'hc000_0000_0000_0000);
    add_pair(64'h7ff8_0000_0000_0000, 64'h3ff0_0000_0000_0000);
    add_pair(64'h3ff0_0000_0000_0000, 64'h7ff0_0000_0000_0001);
    add_pair(64'h7ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000);
    add_pair(64'h3ff0_0000_0000_0000, 64'h8000_0000_0000_0000);
    add_pair(64'h3ff0_0000_0000_0000, 64'h0);
    add_pair(64'h4000_0000_0000_0000, 64'h7ff0_0000_0000_0000);
    add_pair(64'h3ff0_0000_0000_0000, 64'h4000_0000_0000_0000);
    add_pair(64'hc000_0000_0000_0000, 64'h4000_0000_0000_0000);
    add_pair(64'h4018_0000_0000_0000, 64'h4008_0000_0000_0000);
    add_pair(64'h8000_0000_0000_0000, 64'h3ff0_0000_0000_0000);
    add_pair(64'h7fef_ffff_ffff_ffff, 64'h0000_0000_0000_0001);
    add_pair(64'h7fef_ffff_ffff_ffff, 64'h0010_0000_0000_0001);
    add_pair(64'h000f_ffff_ffff_ffff, 64'h0000_0000_0000_0003);
    add_pair(64'h0010_0000_0000_0000, 64'h000f_ffff_ffff_ffff);
    add_pair(64'h4340_0000_0000_0001, 64'h3ff8_0000_0000_0000);
    add_pair(64'hffef_ffff_ffff_ffff, 64'h7fef_ffff_ffff_fffe);
    add_pair(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_nan(nan_values[ph]);
      for (int i = 0; i < 70; i++) begin
        if ($urandom_range(0, 3) == 0)
          add_pair(rand_double(), rand_double());
        else
          add_pair({$urandom, $urandom}, {$urandom, $urandom});
      end
      if (ph == 1) begin
        while (pending_ops.size() > 60) @(posedge clk);
        hold_req = 1'b1;
        wait (hold_off != 0);
        hold_req = 1'b0;
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("double_float_remainder_test: clean");
    end else begin
      $display("double_float_remainder_test: errors");
    end
    $finish;
  end

endmodule
